/* rtl/core/jpt_pkg.sv */
// shared types, constants and codes of the joint pid torque core
package jpt_pkg;

	localparam int JointCount   = 6;
	localparam int JointW       = 3;
	localparam int DataW        = 32;
	localparam int DtW          = 16;
	localparam int LimitW       = 31;
	localparam int CfgIdxW      = 3;
	localparam int QueueDepth   = 2;
	localparam int AccW         = 52;

	localparam logic [DataW-1:0]  PropGainRst      = 32'd3276800;
	localparam logic [DataW-1:0]  DerivGainRst     = 32'd655360;
	localparam logic [DataW-1:0]  IntegGainRst     = 32'd0;
	localparam logic [LimitW-1:0] TorqueLimitRst   = 31'd7864320;
	localparam logic [LimitW-1:0] IntegralLimitRst = 31'd327680;
	localparam logic [DtW-1:0]    DefaultPeriodRst = 16'd262;

	typedef struct packed {
		logic [JointW-1:0]       joint_index;
		logic signed [DataW-1:0] position;
		logic signed [DataW-1:0] velocity;
		logic signed [DataW-1:0] ref_position;
		logic signed [DataW-1:0] ref_velocity;
		logic [DtW-1:0]          elapsed_time;
	} sample_t;

	typedef struct packed {
		logic [JointW-1:0]       joint_out;
		logic signed [DataW-1:0] torque;
	} result_t;

	// one queued request: saturated errors and the effective period
	typedef struct packed {
		logic [JointW-1:0]       joint;
		logic signed [DataW-1:0] pos_err;
		logic signed [DataW-1:0] vel_err;
		logic [DtW-1:0]          dt;
	} cmd_t;

	typedef struct packed {
		logic [DataW-1:0]  prop_gain;
		logic [DataW-1:0]  deriv_gain;
		logic [DataW-1:0]  integ_gain;
		logic [LimitW-1:0] torque_limit;
		logic [LimitW-1:0] integral_limit;
	} gains_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_PROP_GAIN      = 3'd0,
		REG_DERIV_GAIN     = 3'd1,
		REG_INTEG_GAIN     = 3'd2,
		REG_TORQUE_LIMIT   = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_DEFAULT_PERIOD = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_DT,
		ST_INTEG,
		ST_ACC_P,
		ST_ACC_D,
		ST_ACC_I,
		ST_FINISH
	} back_state_t;

endpackage

/* rtl/core/jpt_front.sv */
// front end: takes samples, drops bad joints, forms saturated errors and the period
module jpt_front import jpt_pkg::*; #(
	parameter int JOINT_COUNT = JointCount
) (
	input  logic           sample_valid,
	output logic           sample_stall,
	input  sample_t        sample,
	input  logic [DtW-1:0] default_period,
	input  logic           queue_full,
	output logic           push,
	output cmd_t           cmd
);

	function automatic logic signed [DataW-1:0] sat_diff(
		input logic signed [DataW-1:0] a,
		input logic signed [DataW-1:0] b
	);
		logic signed [DataW:0] d;
		d = {a[DataW-1], a} - {b[DataW-1], b};
		if (d[DataW] != d[DataW-1]) begin
			sat_diff = d[DataW] ? {1'b1, {(DataW-1){1'b0}}} : {1'b0, {(DataW-1){1'b1}}};
		end else begin
			sat_diff = d[DataW-1:0];
		end
	endfunction

	logic joint_ok;

	assign joint_ok     = int'(sample.joint_index) < JOINT_COUNT;
	assign sample_stall = queue_full;
	// out of range joints are taken and dropped
	assign push         = sample_valid && !queue_full && joint_ok;

	always_comb begin
		cmd.joint   = sample.joint_index;
		cmd.pos_err = sat_diff(sample.ref_position, sample.position);
		cmd.vel_err = sat_diff(sample.ref_velocity, sample.velocity);
		cmd.dt      = (sample.elapsed_time == '0) ? default_period : sample.elapsed_time;
	end

endmodule

/* rtl/core/jpt_queue.sv */
// short request queue between front and back
module jpt_queue import jpt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd_in,
	input  logic pop,
	output logic full,
	output logic not_empty,
	output cmd_t cmd_out
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	cmd_t            entry_q [QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		ptr_inc = (p == PtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = count_q == CntW'(QueueDepth);
	assign not_empty = count_q != '0;
	assign cmd_out   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/core/jpt_back.sv */
// back end: integral update and torque sum on one shared 32x32 multiplier
module jpt_back import jpt_pkg::*; #(
	parameter int JOINT_COUNT = JointCount
) (
	input  logic    clk,
	input  logic    arst_n,
	input  gains_t  gains,
	input  logic    q_valid,
	input  cmd_t    q_cmd,
	output logic    q_pop,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int IntegDepth = (JOINT_COUNT < (1 << JointW)) ? JOINT_COUNT : (1 << JointW);
	localparam int IdxW       = (IntegDepth > 1) ? $clog2(IntegDepth) : 1;
	localparam int SumW       = DataW + 2;

	back_state_t state_q, state_d;

	logic signed [DataW-1:0] integ_mem [IntegDepth];

	logic [JointW-1:0]       joint_q;
	logic [DataW-1:0]        e_mag_q;
	logic                    e_neg_q;
	logic [DataW-1:0]        ed_mag_q;
	logic                    ed_neg_q;
	logic [DtW-1:0]          dt_q;
	logic signed [DataW-1:0] integ_q;
	logic [2*DataW-1:0]      prod_q;
	logic                    prod_neg_q;
	logic signed [AccW-1:0]  acc_q;
	logic                    result_valid_q;
	result_t                 result_q;

	logic                    res_load;
	logic                    integ_we;
	logic [DataW-1:0]        mul_a;
	logic [DataW-1:0]        mul_b;
	logic                    mul_neg;

	logic signed [AccW-1:0]  term_mag;
	logic signed [AccW-1:0]  term;
	logic signed [AccW-1:0]  acc_sum;
	logic signed [SumW-1:0]  integ_sum;
	logic signed [SumW-1:0]  integ_lim;
	logic signed [DataW-1:0] integ_new;
	logic signed [AccW-1:0]  tq_lim;
	logic signed [DataW-1:0] torque_sat;
	logic [DataW-1:0]        integ_mag;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (q_valid) state_d = ST_MUL_DT;
			ST_MUL_DT: state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_ACC_P;
			ST_ACC_P:  state_d = ST_ACC_D;
			ST_ACC_D:  state_d = ST_ACC_I;
			ST_ACC_I:  state_d = ST_FINISH;
			ST_FINISH: if (!result_valid_q || !result_stall) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign integ_mag = integ_q[DataW-1] ? DataW'(-integ_q) : DataW'(integ_q);

	// state outputs: multiplier operands and strobes
	always_comb begin
		q_pop    = 1'b0;
		integ_we = 1'b0;
		res_load = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		mul_neg  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				q_pop = q_valid;
			end
			ST_MUL_DT: begin
				mul_a   = e_mag_q;
				mul_b   = {{(DataW-DtW){1'b0}}, dt_q};
				mul_neg = e_neg_q;
			end
			ST_INTEG: begin
				integ_we = 1'b1;
				mul_a    = e_mag_q;
				mul_b    = gains.prop_gain;
				mul_neg  = e_neg_q;
			end
			ST_ACC_P: begin
				mul_a   = ed_mag_q;
				mul_b   = gains.deriv_gain;
				mul_neg = ed_neg_q;
			end
			ST_ACC_D: begin
				mul_a   = integ_mag;
				mul_b   = gains.integ_gain;
				mul_neg = integ_q[DataW-1];
			end
			ST_FINISH: begin
				res_load = !result_valid_q || !result_stall;
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	// product of the previous cycle, truncated toward zero at 16 fraction bits
	assign term_mag = $signed({{(AccW-48){1'b0}}, prod_q[2*DataW-1:16]});
	assign term     = prod_neg_q ? -term_mag : term_mag;
	assign acc_sum  = acc_q + term;

	always_comb begin
		integ_sum = {{2{integ_mem[joint_q[IdxW-1:0]][DataW-1]}},
			integ_mem[joint_q[IdxW-1:0]]} + term[SumW-1:0];
		integ_lim = $signed({{(SumW-LimitW){1'b0}}, gains.integral_limit});
		if (integ_sum > integ_lim) begin
			integ_new = integ_lim[DataW-1:0];
		end else if (integ_sum < -integ_lim) begin
			integ_new = DataW'(-integ_lim);
		end else begin
			integ_new = integ_sum[DataW-1:0];
		end
	end

	always_comb begin
		tq_lim = $signed({{(AccW-LimitW){1'b0}}, gains.torque_limit});
		if (acc_q > tq_lim) begin
			torque_sat = tq_lim[DataW-1:0];
		end else if (acc_q < -tq_lim) begin
			torque_sat = DataW'(-tq_lim);
		end else begin
			torque_sat = acc_q[DataW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			for (int i = 0; i < IntegDepth; i++) begin
				integ_mem[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (integ_we) begin
				integ_mem[joint_q[IdxW-1:0]] <= integ_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q     <= mul_a * mul_b;
		prod_neg_q <= mul_neg;
		if (q_pop) begin
			joint_q  <= q_cmd.joint;
			e_neg_q  <= q_cmd.pos_err[DataW-1];
			e_mag_q  <= q_cmd.pos_err[DataW-1] ? DataW'(-q_cmd.pos_err) : DataW'(q_cmd.pos_err);
			ed_neg_q <= q_cmd.vel_err[DataW-1];
			ed_mag_q <= q_cmd.vel_err[DataW-1] ? DataW'(-q_cmd.vel_err) : DataW'(q_cmd.vel_err);
			dt_q     <= q_cmd.dt;
		end
		if (integ_we) begin
			integ_q <= integ_new;
		end
		case (state_q)
			ST_ACC_P: acc_q <= term;
			ST_ACC_D: acc_q <= acc_sum;
			ST_ACC_I: acc_q <= acc_sum;
			default:  acc_q <= acc_q;
		endcase
		if (res_load) begin
			result_q.joint_out <= joint_q;
			result_q.torque    <= torque_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/joint_pid_torque_core.sv */
// per-joint pid torque core: register bank, front end, request queue and back end
// a sample passes the queue and back end states idle (pop), mul_dt, integ (integral
// update), acc_p, acc_d, acc_i and finish (clamp); a new sample is popped only after
//   the last finishes, as four products share a single 32x32 multiplier
// the front end takes samples every cycle until the 2-entry queue fills
// reset clears the gains to defaults and every joint integral to zero at once
module joint_pid_torque_core import jpt_pkg::*; #(
	parameter int JOINT_COUNT = JointCount
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DataW-1:0]   cfg_wdata,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result
);

	gains_t         gains_q;
	logic [DtW-1:0] default_period_q;

	logic push;
	logic pop;
	logic queue_full;
	logic queue_not_empty;
	cmd_t cmd_front;
	cmd_t cmd_back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop_gain      <= PropGainRst;
			gains_q.deriv_gain     <= DerivGainRst;
			gains_q.integ_gain     <= IntegGainRst;
			gains_q.torque_limit   <= TorqueLimitRst;
			gains_q.integral_limit <= IntegralLimitRst;
			default_period_q       <= DefaultPeriodRst;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:      gains_q.prop_gain      <= cfg_wdata;
				REG_DERIV_GAIN:     gains_q.deriv_gain     <= cfg_wdata;
				REG_INTEG_GAIN:     gains_q.integ_gain     <= cfg_wdata;
				REG_TORQUE_LIMIT:   gains_q.torque_limit   <= cfg_wdata[LimitW-1:0];
				REG_INTEGRAL_LIMIT: gains_q.integral_limit <= cfg_wdata[LimitW-1:0];
				REG_DEFAULT_PERIOD: default_period_q       <= cfg_wdata[DtW-1:0];
				default:            default_period_q       <= default_period_q;
			endcase
		end
	end

	jpt_front #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_front (
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sample        (sample),
		.default_period(default_period_q),
		.queue_full    (queue_full),
		.push          (push),
		.cmd           (cmd_front)
	);

	jpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.cmd_in   (cmd_front),
		.pop      (pop),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.cmd_out  (cmd_back)
	);

	jpt_back #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.gains       (gains_q),
		.q_valid     (queue_not_empty),
		.q_cmd       (cmd_back),
		.q_pop       (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

/* rtl/core/jpt_checker.sv */
// port-level checks for the joint pid torque core and their bind
module jpt_checker import jpt_pkg::*; #(
	parameter int JOINT_COUNT = JointCount
) (
	input logic    clk,
	input logic    arst_n,
	input logic    sample_valid,
	input logic    sample_stall,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// a stalled result stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// joints out of range never produce a result
	a_joint_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> int'(result.joint_out) < JOINT_COUNT)
		else $error("result for out of range joint");

	// the queue only fills right after a sample is offered
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sample_stall) |-> $past(sample_valid))
		else $error("input stall without a preceding request");

endmodule

bind joint_pid_torque_core jpt_checker #(.JOINT_COUNT(JOINT_COUNT)) u_jpt_checker (.*);
